// ===== design/sdg_pkg.sv =====
// ----------------------------------------------------------------------------
// sdg_pkg
// Shared types, codes and sizing constants for the step/direction generator.
// ----------------------------------------------------------------------------
package sdg_pkg;

  // Internal width of the position, target and distance registers.
  localparam int POSITION_BITS = 32;
  // Internal width of the microsecond timestamps.
  localparam int TIME_BITS = 32;

  // Fixed widths of the external fields.
  localparam int OP_W   = 3;
  localparam int WORD_W = 32;
  localparam int CFG_INDEX_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_POS_TICK   = 3'd0,
    OP_SPEED_TICK = 3'd1,
    OP_REL_MOVE   = 3'd2,
    OP_ABS_MOVE   = 3'd3,
    OP_SET_POS    = 3'd4
  } op_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_STEP_WIDTH = 2'd0,
    CFG_LOCKED     = 2'd1
  } cfg_index_t;

  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic [WORD_W-1:0]        now_us;
    logic signed [WORD_W-1:0] value;
    logic                     forward;
  } item_t;

  typedef struct packed {
    logic                     ok;
    logic                     step_level;
    logic                     dir_level;
    logic signed [WORD_W-1:0] position;
    logic signed [WORD_W-1:0] distance_left;
    logic                     is_locked;
  } result_t;

  typedef struct packed {
    logic [WORD_W-1:0] step_width_us;
    logic              locked;
  } cfg_t;

endpackage

// ===== design/sdg_cfg.sv =====
// ----------------------------------------------------------------------------
// sdg_cfg
// Configuration register file: step width and lock.
// ----------------------------------------------------------------------------
module sdg_cfg import sdg_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]      cfg_data,
  output cfg_t                   cfg
);

  cfg_t regs;

  // The register file never back-pressures.
  assign cfg_ready = 1'b1;
  assign cfg       = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.step_width_us <= WORD_W'(1000);
      regs.locked        <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_STEP_WIDTH: regs.step_width_us <= cfg_data;
        CFG_LOCKED:     regs.locked        <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

// ===== design/sdg_core.sv =====
// ----------------------------------------------------------------------------
// sdg_core
// Motion state and its single-pass update for one registered item.
// ----------------------------------------------------------------------------
module sdg_core import sdg_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t result
);

  localparam int PW = POSITION_BITS;
  localparam int TW = TIME_BITS;

  logic [PW-1:0] target_pos, target_pos_next;
  logic [PW-1:0] current_pos, current_pos_next;
  logic [PW-1:0] distance_to_go, distance_to_go_next;
  logic [TW-1:0] last_step_time, last_step_time_next;
  logic          pulse_high, pulse_high_next;
  logic          dir_pin_level, dir_pin_level_next;

  logic [PW-1:0] value_pos;
  logic [PW-1:0] dist_recalc;
  logic [PW-1:0] rel_target;
  logic [TW-1:0] now_t;
  logic [TW-1:0] elapsed_us;
  logic          elapsed;
  logic          is_tick;
  logic          make_edge;
  logic          positive;

  assign value_pos   = PW'(item.value);
  assign now_t       = TW'(item.now_us);
  assign elapsed_us  = now_t - last_step_time;
  assign elapsed     = elapsed_us >= TW'(cfg.step_width_us);
  assign dist_recalc = target_pos - current_pos;
  assign rel_target  = target_pos + value_pos;
  assign is_tick     = (op_t'(item.op) == OP_POS_TICK) || (op_t'(item.op) == OP_SPEED_TICK);

  always_comb begin
    target_pos_next     = target_pos;
    current_pos_next    = current_pos;
    distance_to_go_next = distance_to_go;
    last_step_time_next = last_step_time;
    pulse_high_next     = pulse_high;
    dir_pin_level_next  = dir_pin_level;
    make_edge           = 1'b0;
    positive            = 1'b0;

    unique case (op_t'(item.op))
      OP_POS_TICK: begin
        if (!cfg.locked && elapsed && (distance_to_go != '0)) begin
          make_edge           = 1'b1;
          distance_to_go_next = dist_recalc;
          positive            = (dist_recalc != '0) && !dist_recalc[PW-1];
        end
      end
      OP_SPEED_TICK: begin
        if (!cfg.locked && elapsed) begin
          make_edge = 1'b1;
          positive  = item.forward;
        end
      end
      OP_REL_MOVE: begin
        target_pos_next     = rel_target;
        distance_to_go_next = rel_target - current_pos;
      end
      OP_ABS_MOVE: begin
        target_pos_next     = value_pos;
        distance_to_go_next = value_pos - current_pos;
      end
      OP_SET_POS: begin
        current_pos_next = value_pos;
      end
      default: ;
    endcase

    // A step edge moves the position only on the rising half of the step pulse.
    if (make_edge) begin
      last_step_time_next = now_t;
      dir_pin_level_next  = positive;
      pulse_high_next     = !pulse_high;
      if (!pulse_high) begin
        current_pos_next = positive ? current_pos + PW'(1) : current_pos - PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_pos     <= '0;
      current_pos    <= '0;
      distance_to_go <= '0;
      last_step_time <= '0;
      pulse_high     <= 1'b0;
      dir_pin_level  <= 1'b0;
    end else if (fire) begin
      target_pos     <= target_pos_next;
      current_pos    <= current_pos_next;
      distance_to_go <= distance_to_go_next;
      last_step_time <= last_step_time_next;
      pulse_high     <= pulse_high_next;
      dir_pin_level  <= dir_pin_level_next;
    end
  end

  always_comb begin
    result.ok            = !(is_tick && cfg.locked);
    result.step_level    = pulse_high_next;
    result.dir_level     = dir_pin_level_next;
    result.position      = WORD_W'(current_pos_next);
    result.distance_left = WORD_W'(distance_to_go_next);
    result.is_locked     = cfg.locked;
  end

endmodule

// ===== design/stepper_step_dir_generator.sv =====
// ----------------------------------------------------------------------------
// stepper_step_dir_generator
// Step/direction pulse generator without acceleration, one beat per command.
// ----------------------------------------------------------------------------
//
//   Channel | Handshake               | Payload
//   --------+-------------------------+---------------------------------------
//   input   | in_valid / in_stall     | op, now_us, value, forward
//   output  | out_valid / out_stall   | ok, step_level, dir_level, position,
//           |                         | distance_left, is_locked
//   config  | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// Every input beat lands in the input register; the edge at which it advances
// updates the motion state and loads the result register, which raises
// out_valid. One beat per cycle flows when the output is not stalled. The
// rate is set by the single pass through sdg_core, one 32-bit add and
// subtract chain plus a time compare.
// Synchronous reset clears both pipeline valid bits, the motion state and the
// configuration (step width 1000 us, unlocked). A stall on the output holds
// the result register; the input register then holds too and in_stall rises,
// while a free result register lets the input side keep streaming.
module stepper_step_dir_generator import sdg_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  // Input channel.
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [OP_W-1:0]          op,
  input  logic [WORD_W-1:0]        now_us,
  input  logic signed [WORD_W-1:0] value,
  input  logic                     forward,
  // Output channel.
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     ok,
  output logic                     step_level,
  output logic                     dir_level,
  output logic signed [WORD_W-1:0] position,
  output logic signed [WORD_W-1:0] distance_left,
  output logic                     is_locked,
  // Configuration write channel.
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_INDEX_W-1:0]   cfg_index,
  input  logic [WORD_W-1:0]        cfg_data
);

  cfg_t    cfg;
  item_t   in_item;
  logic    in_item_valid;
  result_t core_result;
  result_t out_result;
  logic    advance;

  sdg_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The held item is processed whenever the result register is free or is
  // being emptied in this same cycle.
  assign advance  = in_item_valid && (!out_valid || !out_stall);
  assign in_stall = in_item_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_item_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_item_valid <= 1'b1;
    end else if (advance) begin
      in_item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item.op      <= op;
      in_item.now_us  <= now_us;
      in_item.value   <= value;
      in_item.forward <= forward;
    end
  end

  sdg_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .item   (in_item),
    .cfg    (cfg),
    .result (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= core_result;
    end
  end

  assign ok            = out_result.ok;
  assign step_level    = out_result.step_level;
  assign dir_level     = out_result.dir_level;
  assign position      = out_result.position;
  assign distance_left = out_result.distance_left;
  assign is_locked     = out_result.is_locked;

endmodule

// ===== design/sdg_checker.sv =====
// ----------------------------------------------------------------------------
// sdg_checker
// Port-level checks for the step/direction generator, bound to the top level.
// ----------------------------------------------------------------------------
module sdg_checker import sdg_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic                     ok,
  input logic                     step_level,
  input logic signed [WORD_W-1:0] position,
  input logic                     is_locked
);

  // A stalled result holds its beat.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(position) && $stable(step_level))
    else $error("stalled result changed");

  // Only a refused tick reports failure, and that needs the lock set.
  a_fail_locked: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ok |-> is_locked)
    else $error("failure reported while unlocked");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  // Input back-pressure only comes from a stalled, full result register.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

endmodule

bind stepper_step_dir_generator sdg_checker u_sdg_checker (
  .clk        (clk),
  .rst        (rst),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .ok         (ok),
  .step_level (step_level),
  .position   (position),
  .is_locked  (is_locked)
);

// ===== test/stepper_step_dir_generator_tb.sv =====
// ----------------------------------------------------------------------------
// stepper_step_dir_generator_tb
// Self-checking bench for the step/direction generator. A behavioral motion
// model predicts every result beat from the accepted command beats and the
// register writes. The bench runs directed corner cases, register extremes,
// random motion sequences with random idling on both channels, and a
// back-pressure phase that fills the pipeline.
// ----------------------------------------------------------------------------
module stepper_step_dir_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sdg_pkg::*;

  // Op codes 5 to 7 have no name in the package; the block ignores them.
  localparam logic [OP_W-1:0] OP_FIRST_UNUSED = 3'd5;
  localparam logic [WORD_W-1:0] RESET_STEP_WIDTH = 32'd1000;
  localparam int IDLE_PERCENT = 26;
  localparam int RANDOM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 45;

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_stall;
  logic [OP_W-1:0]          op;
  logic [WORD_W-1:0]        now_us;
  logic signed [WORD_W-1:0] value;
  logic                     forward;
  logic                     out_valid;
  logic                     out_stall;
  logic                     ok;
  logic                     step_level;
  logic                     dir_level;
  logic signed [WORD_W-1:0] position;
  logic signed [WORD_W-1:0] distance_left;
  logic                     is_locked;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_INDEX_W-1:0]   cfg_index;
  logic [WORD_W-1:0]        cfg_data;

  stepper_step_dir_generator dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .op(op),
    .now_us(now_us),
    .value(value),
    .forward(forward),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .ok(ok),
    .step_level(step_level),
    .dir_level(dir_level),
    .position(position),
    .distance_left(distance_left),
    .is_locked(is_locked),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Motion model state. It mirrors the block's registers and is only touched
  // by the beat monitor, so it advances in the same order as the hardware.
  logic [POSITION_BITS-1:0] mot_target;
  logic [POSITION_BITS-1:0] mot_position;
  logic [POSITION_BITS-1:0] mot_distance;
  logic [TIME_BITS-1:0]     mot_last_edge;
  logic                     mot_pulse;
  logic                     mot_dir;
  logic [WORD_W-1:0]        mot_width;
  logic                     mot_locked;

  // Results predicted for accepted command beats, oldest first.
  result_t pending_results[$];

  int  mismatch_count;
  int  items_sent;
  int  results_checked;
  int  hold_cycles;
  bit  tx_idle_on;
  bit  rx_idle_on;
  // Stimulus-side view of time and step width, used to pace the ticks.
  logic [TIME_BITS-1:0] clock_us;
  logic [WORD_W-1:0]    phase_width;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // One edge of the step pin. The position only moves on the rising half.
  function automatic void step_edge(logic [TIME_BITS-1:0] stamp, logic up);
    mot_last_edge = stamp;
    mot_dir = up;
    if (!mot_pulse) begin
      mot_position = up ? mot_position + 1'b1 : mot_position - 1'b1;
    end
    mot_pulse = ~mot_pulse;
  endfunction

  // Applies one command beat to the motion model and returns the result the
  // block has to produce for it.
  function automatic result_t advance_motion(item_t cmd);
    result_t              res;
    logic [TIME_BITS-1:0] since_edge;
    logic                 tick_ok;
    tick_ok = 1'b1;
    // Timestamps wrap, so the elapsed time is a plain modular difference.
    since_edge = cmd.now_us - mot_last_edge;
    case (cmd.op)
      OP_POS_TICK, OP_SPEED_TICK: begin
        if (mot_locked) begin
          tick_ok = 1'b0;
        end else if (since_edge >= mot_width) begin
          if (cmd.op == OP_SPEED_TICK) begin
            step_edge(cmd.now_us, cmd.forward);
          end else if (mot_distance != '0) begin
            // The stored distance gates the edge, then it is recomputed and
            // its sign sets the direction; zero counts as negative.
            mot_distance = mot_target - mot_position;
            step_edge(cmd.now_us,
                      mot_distance != '0 && !mot_distance[POSITION_BITS-1]);
          end
        end
      end
      OP_REL_MOVE: begin
        mot_target = mot_target + cmd.value;
        mot_distance = mot_target - mot_position;
      end
      OP_ABS_MOVE: begin
        mot_target = cmd.value;
        mot_distance = mot_target - mot_position;
      end
      OP_SET_POS: begin
        // Setting the position leaves the stored distance stale on purpose.
        mot_position = cmd.value;
      end
      default: begin
      end
    endcase
    res.ok = tick_ok;
    res.step_level = mot_pulse;
    res.dir_level = mot_dir;
    res.position = mot_position;
    res.distance_left = mot_distance;
    res.is_locked = mot_locked;
    return res;
  endfunction

  function automatic void check_field(string name, logic [WORD_W-1:0] want,
                                      logic [WORD_W-1:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // Watches all three channels at the rising edge. The result beat is checked
  // before a new command beat is predicted, since a result leaving the block
  // always belongs to an earlier command.
  always @(posedge clk) begin : beat_monitor
    item_t   cmd;
    result_t want;
    if (rst) begin
      mot_target = '0;
      mot_position = '0;
      mot_distance = '0;
      mot_last_edge = '0;
      mot_pulse = 1'b0;
      mot_dir = 1'b0;
      mot_width = RESET_STEP_WIDTH;
      mot_locked = 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $display("%0t ns: result beat arrived with no command outstanding", $time);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          results_checked++;
          check_field("ok", want.ok, ok);
          check_field("step_level", want.step_level, step_level);
          check_field("dir_level", want.dir_level, dir_level);
          check_field("position", want.position, position);
          check_field("distance_left", want.distance_left, distance_left);
          check_field("is_locked", want.is_locked, is_locked);
        end
      end
      if (in_valid && !in_stall) begin
        cmd.op = op;
        cmd.now_us = now_us;
        cmd.value = value;
        cmd.forward = forward;
        pending_results.push_back(advance_motion(cmd));
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_STEP_WIDTH: mot_width = cfg_data;
          CFG_LOCKED:     mot_locked = cfg_data[0];
          default: begin
          end
        endcase
      end
    end
  end

  // Receiver side. A requested hold keeps the output stalled for a counted
  // number of cycles; otherwise the stall is random or off.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_stall <= 1'b1;
      end else if (rx_idle_on) begin
        out_stall <= ($urandom_range(0, 99) < IDLE_PERCENT);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Offers one command beat and returns at the falling edge after it was
  // taken. Valid stays high so back-to-back beats need no extra step; it only
  // drops for an idle gap or when the sender waits for the block to drain.
  // Each cycle is idle with the same chance, so the idle share matches it.
  task automatic send_item(input logic [OP_W-1:0] cmd_op, input logic [WORD_W-1:0] cmd_now,
                           input logic [WORD_W-1:0] cmd_value, input logic cmd_fwd);
    while (tx_idle_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    op <= cmd_op;
    now_us <= cmd_now;
    value <= cmd_value;
    forward <= cmd_fwd;
    do @(posedge clk); while (in_stall);
    items_sent++;
    @(negedge clk);
  endtask

  // Stops offering beats and waits until every predicted result has come.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_register(input cfg_index_t idx, input logic [WORD_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Moves the stimulus clock forward by a step that suits the current width,
  // so that some ticks land before the next edge is due and some after.
  function automatic logic [TIME_BITS-1:0] next_time();
    if (phase_width > 32'd1000) begin
      clock_us = clock_us + $urandom;
    end else begin
      clock_us = clock_us + $urandom_range(0, 2 * phase_width + 2);
    end
    return clock_us;
  endfunction

  // Small signed offsets keep moves short enough to be finished by ticks;
  // now and then a full 32-bit value is used instead.
  function automatic logic [WORD_W-1:0] move_value();
    logic [WORD_W-1:0] offset;
    if ($urandom_range(0, 3) == 0) begin
      return $urandom;
    end
    offset = $urandom_range(0, 40);
    return offset - 32'd20;
  endfunction

  // Reset values, speed ticks in both directions, position ticks with and
  // without distance, move extremes, the stale distance after a set position,
  // an edge on zero distance, ignored op codes and timestamp wrap.
  task automatic test_directed();
    send_item(OP_SPEED_TICK, 32'd0, 32'hFFFF_FFFF, 1'b1);
    send_item(OP_SPEED_TICK, 32'd1000, 32'd0, 1'b1);
    send_item(OP_SPEED_TICK, 32'd2000, 32'd0, 1'b0);
    send_item(OP_SPEED_TICK, 32'd3000, 32'd0, 1'b0);
    // No distance stored yet, so a position tick must not step.
    send_item(OP_POS_TICK, 32'd4000, 32'd0, 1'b0);
    send_item(OP_ABS_MOVE, 32'd0, 32'd3, 1'b0);
    for (int k = 0; k < 3; k++) begin
      send_item(OP_POS_TICK, 32'd5000 + k * 1000, 32'd0, 1'b0);
    end
    send_item(OP_REL_MOVE, 32'd0, 32'h7FFF_FFFF, 1'b1);
    send_item(OP_REL_MOVE, 32'd0, 32'h8000_0000, 1'b0);
    // The distance kept after a set position is the old one until an edge.
    send_item(OP_SET_POS, 32'd0, 32'h8000_0000, 1'b0);
    send_item(OP_POS_TICK, 32'd9000, 32'd0, 1'b0);
    // Target equal to the position: the edge happens with direction negative.
    send_item(OP_ABS_MOVE, 32'd0, 32'd100, 1'b0);
    send_item(OP_SET_POS, 32'd0, 32'd100, 1'b0);
    send_item(OP_POS_TICK, 32'd10000, 32'd0, 1'b0);
    for (int u = 0; u < 3; u++) begin
      send_item(OP_FIRST_UNUSED + OP_W'(u), $urandom, $urandom, u[0]);
    end
    // The last edge was at 10000; the following tick wraps the timestamp.
    send_item(OP_SPEED_TICK, 32'hFFFF_FFFF, 32'd0, 1'b1);
    send_item(OP_SPEED_TICK, 32'h0000_03E7, 32'd0, 1'b1);
  endtask

  // Step width zero and all ones, then ticks and commands while locked.
  task automatic test_register_extremes();
    wait_idle();
    write_register(CFG_STEP_WIDTH, 32'd0);
    send_item(OP_SPEED_TICK, 32'h0001_0000, 32'd0, 1'b1);
    send_item(OP_SPEED_TICK, 32'h0001_0000, 32'd0, 1'b0);
    wait_idle();
    write_register(CFG_STEP_WIDTH, 32'hFFFF_FFFF);
    // Only a timestamp one below the last edge is far enough away.
    send_item(OP_SPEED_TICK, 32'h0001_0000, 32'd0, 1'b1);
    send_item(OP_SPEED_TICK, 32'h0000_FFFF, 32'd0, 1'b1);
    wait_idle();
    write_register(CFG_LOCKED, 32'd1);
    send_item(OP_POS_TICK, 32'hFFFF_FFFF, 32'd0, 1'b0);
    send_item(OP_SPEED_TICK, 32'hFFFF_FFFF, 32'd0, 1'b1);
    send_item(OP_REL_MOVE, 32'd0, 32'd5, 1'b0);
    send_item(OP_SET_POS, 32'd0, 32'hFFFF_FFF9, 1'b0);
    wait_idle();
    write_register(CFG_LOCKED, 32'd0);
    write_register(CFG_STEP_WIDTH, RESET_STEP_WIDTH);
  endtask

  // One random stretch of commands. Most stretches are a move followed by
  // enough position ticks to walk toward the target, or a burst of speed
  // ticks; the rest are set positions, ignored op codes and timestamp jumps.
  task automatic random_sequence();
    int  pick;
    int  count;
    logic dir;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      if ($urandom_range(0, 1) == 0) begin
        send_item(OP_REL_MOVE, $urandom, move_value(), 1'($urandom_range(0, 1)));
      end else begin
        send_item(OP_ABS_MOVE, $urandom, mot_position + move_value(),
                  1'($urandom_range(0, 1)));
      end
      count = $urandom_range(2, 12);
      repeat (count) send_item(OP_POS_TICK, next_time(), $urandom, 1'($urandom_range(0, 1)));
    end else if (pick < 70) begin
      dir = 1'($urandom_range(0, 1));
      count = $urandom_range(2, 10);
      repeat (count) send_item(OP_SPEED_TICK, next_time(), $urandom, dir);
    end else if (pick < 80) begin
      send_item(OP_SET_POS, $urandom, move_value(), 1'($urandom_range(0, 1)));
    end else if (pick < 88) begin
      send_item(OP_FIRST_UNUSED + OP_W'($urandom_range(0, 2)), $urandom, $urandom,
                1'($urandom_range(0, 1)));
    end else begin
      clock_us = $urandom;
      send_item($urandom_range(0, 1) ? OP_SPEED_TICK : OP_POS_TICK, clock_us, $urandom,
                1'($urandom_range(0, 1)));
    end
  endtask

  // Random phases, each with its own register setting written while the
  // block is idle. The first phase runs without any idling on either side.
  task automatic test_random_motion();
    int phase_goal;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_idle();
      tx_idle_on = (ph != 0);
      rx_idle_on = (ph != 0);
      case (ph)
        0:       phase_width = 32'd0;
        3:       phase_width = $urandom;
        default: phase_width = $urandom_range(1, 40);
      endcase
      write_register(CFG_STEP_WIDTH, phase_width);
      write_register(CFG_LOCKED, WORD_W'(ph == 5));
      phase_goal = items_sent + ITEMS_PER_PHASE;
      while (items_sent < phase_goal) random_sequence();
    end
  endtask

  // The receiver holds off for a long stretch while the sender keeps going,
  // so the pipeline fills and the input stalls. Afterwards the sender pauses
  // until every result is back, then resumes.
  task automatic test_back_pressure();
    wait_idle();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    phase_width = 32'd4;
    write_register(CFG_STEP_WIDTH, phase_width);
    write_register(CFG_LOCKED, 32'd0);
    hold_cycles = 80;
    send_item(OP_ABS_MOVE, 32'd0, mot_position + 32'd12, 1'b0);
    repeat (20) send_item(OP_POS_TICK, next_time(), $urandom, 1'b0);
    wait_idle();
    rx_idle_on = 1'b1;
    tx_idle_on = 1'b1;
    send_item(OP_REL_MOVE, 32'd0, 32'hFFFF_FFF0, 1'b1);
    repeat (15) send_item(OP_POS_TICK, next_time(), $urandom, 1'b1);
  endtask

  initial begin
    int waited;
    rst = 1'b1;
    in_valid = 1'b0;
    op = OP_POS_TICK;
    now_us = '0;
    value = '0;
    forward = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_STEP_WIDTH;
    cfg_data = '0;
    mismatch_count = 0;
    items_sent = 0;
    results_checked = 0;
    hold_cycles = 0;
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    clock_us = '0;
    phase_width = RESET_STEP_WIDTH;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    test_register_extremes();
    test_random_motion();
    test_back_pressure();

    // Drain with a bound; anything still outstanding afterwards is an error.
    in_valid <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < 2000) begin
      @(negedge clk);
      waited++;
    end
    repeat (6) @(negedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t ns: %0d expected results never arrived", $time, pending_results.size());
      mismatch_count += pending_results.size();
    end

    $display("Run covered %0d command beats and %0d checked result beats over directed,",
             items_sent, results_checked);
    $display("register extreme, random motion and back-pressure phases; %0d mismatches.",
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Generous watchdog, far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("Timeout: the block stopped moving beats");
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
